>>> rtl/gst_pkg.sv
// Shared types, constants and round functions for the GOST 28147-89 cipher.
// Depends on nothing; every other file but gst_checker imports it.
package gst_pkg;

   localparam int NUM_ROUNDS = 32;
   localparam int ROUND_W    = $clog2(NUM_ROUNDS);
   localparam int KEY_WORDS  = 8;
   localparam int KEY_IDX_W  = $clog2(KEY_WORDS);
   localparam int WORD_W     = 32;
   localparam int ROT_AMOUNT = 11;

   // Mode codes carried with each transaction.
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [3:0] sbox_type [8][16];

   // Substitution boxes; box i serves nibble i counted from the LSB end.
   localparam sbox_type SBOX = '{
      '{4'h4, 4'ha, 4'h9, 4'h2, 4'hd, 4'h8, 4'h0, 4'he,
        4'h6, 4'hb, 4'h1, 4'hc, 4'h7, 4'hf, 4'h5, 4'h3},
      '{4'he, 4'hb, 4'h4, 4'hc, 4'h6, 4'hd, 4'hf, 4'ha,
        4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
      '{4'h5, 4'h8, 4'h1, 4'hd, 4'ha, 4'h3, 4'h4, 4'h2,
        4'he, 4'hf, 4'hc, 4'h7, 4'h6, 4'h0, 4'h9, 4'hb},
      '{4'h7, 4'hd, 4'ha, 4'h1, 4'h0, 4'h8, 4'h9, 4'hf,
        4'he, 4'h4, 4'h6, 4'hc, 4'hb, 4'h2, 4'h5, 4'h3},
      '{4'h6, 4'hc, 4'h7, 4'h1, 4'h5, 4'hf, 4'hd, 4'h8,
        4'h4, 4'ha, 4'h9, 4'he, 4'h0, 4'h3, 4'hb, 4'h2},
      '{4'h4, 4'hb, 4'ha, 4'h0, 4'h7, 4'h2, 4'h1, 4'hd,
        4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hc, 4'hf, 4'he},
      '{4'hd, 4'hb, 4'h4, 4'h1, 4'h3, 4'hf, 4'h5, 4'h9,
        4'h0, 4'ha, 4'he, 4'h7, 4'h6, 4'h8, 4'h2, 4'hc},
      '{4'h1, 4'hf, 4'hd, 4'h0, 4'h5, 4'h7, 4'ha, 4'h4,
        4'h9, 4'h2, 4'h3, 4'he, 4'h6, 4'hb, 4'h8, 4'hc}
   };

   // One pipeline slot: valid bit, mode and the two Feistel halves.
   typedef struct packed {
      logic              valid;
      logic              mode;
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } stage_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_array_type;

   // Round function: modular add, nibble substitution, rotate left by eleven.
   function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] half,
                                                  input logic [WORD_W-1:0] key);
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] sub;
      sum = half + key;
      for (int n = 0; n < 8; n++) begin
         sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
      end
      return {sub[WORD_W-ROT_AMOUNT-1:0], sub[WORD_W-1:WORD_W-ROT_AMOUNT]};
   endfunction

   // Key schedule: encryption runs 0..7 three times then 7..0; decryption
   // runs 0..7 once then 7..0 three times.
   function automatic logic [KEY_IDX_W-1:0] key_sel(input logic [ROUND_W-1:0] rnd,
                                                    input logic mode);
      logic [KEY_IDX_W-1:0] fwd;
      logic                 forward;
      fwd = rnd[KEY_IDX_W-1:0];
      if (mode == MODE_ENCRYPT) begin
         forward = (rnd[ROUND_W-1:KEY_IDX_W] != 2'b11);
      end else begin
         forward = (rnd[ROUND_W-1:KEY_IDX_W] == 2'b00);
      end
      return forward ? fwd : ~fwd;
   endfunction

endpackage

>>> rtl/gst_key_regs.sv
// Key register file: eight 32-bit key words written through the CSR port.
// Depends on gst_pkg for widths and the key array type.
module gst_key_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [gst_pkg::KEY_IDX_W-1:0] csr_index,
   input  logic [gst_pkg::WORD_W-1:0]  csr_data,
   output gst_pkg::key_array_type      key_words
);
   import gst_pkg::*;

   key_array_type key_ff;
   key_array_type key_in;

   // Replace the addressed word on a write.
   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         key_in[csr_index] = csr_data;
      end
   end

   // Keys reset to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key_words = key_ff;

endmodule

>>> rtl/gst_round.sv
// One Feistel round followed by its pipeline register and local flow control.
// Depends on gst_pkg for the stage struct and the round function.
module gst_round (
   input  logic                       clock,
   input  logic                       reset,
   input  gst_pkg::stage_type         stage_in,
   input  logic [gst_pkg::WORD_W-1:0] key_word,
   input  logic                       down_ready,
   output logic                       up_ready,
   output gst_pkg::stage_type         stage_out
);
   import gst_pkg::*;

   stage_type stage_ff;
   stage_type stage_in_next;

   // The slot can take a new transaction when empty or when it drains now.
   assign up_ready = !stage_ff.valid || down_ready;

   // Round logic: new right is left XOR F(right), new left is old right.
   always_comb begin
      stage_in_next       = stage_in;
      stage_in_next.left  = stage_in.right;
      stage_in_next.right = stage_in.left ^ round_fn(stage_in.right, key_word);
   end

   // Valid bit is reset; payload loads only with a real transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (up_ready) begin
         stage_ff.valid <= stage_in.valid;
         if (stage_in.valid) begin
            stage_ff.mode  <= stage_in_next.mode;
            stage_ff.left  <= stage_in_next.left;
            stage_ff.right <= stage_in_next.right;
         end
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> rtl/gost_block_cipher.sv
// Top level of the GOST 28147-89 cipher: key registers and a 32-stage round pipeline.
// Depends on gst_pkg, gst_key_regs and gst_round.
//
//   Channel  Ports                             Direction  Transaction
//   req      req_valid/req_ready, mode, block  in         one block to cipher
//   rsp      rsp_valid/rsp_ready, result       out        one ciphered block
//   csr      csr_write, csr_index, csr_data    in         one key word write
//
// One round per pipeline stage: a block accepted on the request channel passes
// through every stage register in order before it is offered on the response
// channel, and one block can enter every cycle while req_ready is high.
// Each stage holds its transaction while the stage below is full and stalled,
// and empty stages fill behind it, so req_ready drops only with all 32 full.
// Synchronous reset clears the valid bits and sets every key word to zero.
module gost_block_cipher (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic [63:0]                  req_data_block,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [63:0]                  rsp_result_block,
   input  logic                         csr_write,
   input  logic [gst_pkg::KEY_IDX_W-1:0] csr_index,
   input  logic [gst_pkg::WORD_W-1:0]   csr_data
);
   import gst_pkg::*;

   key_array_type key_words;
   stage_type     stage_chain [NUM_ROUNDS+1];
   logic          ready_chain [NUM_ROUNDS+1];

   gst_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .key_words (key_words)
   );

   // Request enters the head of the pipeline.
   always_comb begin
      stage_chain[0].valid = req_valid;
      stage_chain[0].mode  = req_mode;
      stage_chain[0].left  = req_data_block[63:32];
      stage_chain[0].right = req_data_block[31:0];
   end

   assign req_ready               = ready_chain[0];
   assign ready_chain[NUM_ROUNDS] = rsp_ready;

   // One round instance per stage, each picking its key word by mode.
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      logic [WORD_W-1:0] round_key;

      assign round_key = key_words[key_sel(ROUND_W'(r), stage_chain[r].mode)];

      gst_round u_round (
         .clock      (clock),
         .reset      (reset),
         .stage_in   (stage_chain[r]),
         .key_word   (round_key),
         .down_ready (ready_chain[r+1]),
         .up_ready   (ready_chain[r]),
         .stage_out  (stage_chain[r+1])
      );
   end

   // The last stage already holds the final swap: right half goes high.
   assign rsp_valid        = stage_chain[NUM_ROUNDS].valid;
   assign rsp_result_block = {stage_chain[NUM_ROUNDS].right, stage_chain[NUM_ROUNDS].left};

endmodule

>>> rtl/gst_checker.sv
// Port-level checks for the cipher top level, bound to every instance.
// Depends only on the port names of gost_block_cipher.
module gst_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_mode,
   input logic [63:0]                  req_data_block,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [63:0]                  rsp_result_block
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An empty last stage means every stage can advance.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty output stage");

   // A draining output lets the whole pipeline advance.
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while output drains");

   // A stalled response holds its block.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_block)))
      else $error("stalled response changed");

   // A waiting request keeps its mode and block until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=>
         (req_valid && $stable(req_mode) && $stable(req_data_block)))
      else $error("waiting request changed");

endmodule

bind gost_block_cipher gst_checker u_gst_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the GOST 28147-89 block cipher pipeline.
// Depends on gst_pkg and gost_block_cipher; predicts each result from its own key copy.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gst_pkg::*;

   localparam int PIPE_DEPTH  = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 23;

   // Substitution table of the cipher, box n for nibble n from the LSB end.
   localparam logic [3:0] SUBST [8][16] = '{
      '{4'h4, 4'ha, 4'h9, 4'h2, 4'hd, 4'h8, 4'h0, 4'he,
        4'h6, 4'hb, 4'h1, 4'hc, 4'h7, 4'hf, 4'h5, 4'h3},
      '{4'he, 4'hb, 4'h4, 4'hc, 4'h6, 4'hd, 4'hf, 4'ha,
        4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
      '{4'h5, 4'h8, 4'h1, 4'hd, 4'ha, 4'h3, 4'h4, 4'h2,
        4'he, 4'hf, 4'hc, 4'h7, 4'h6, 4'h0, 4'h9, 4'hb},
      '{4'h7, 4'hd, 4'ha, 4'h1, 4'h0, 4'h8, 4'h9, 4'hf,
        4'he, 4'h4, 4'h6, 4'hc, 4'hb, 4'h2, 4'h5, 4'h3},
      '{4'h6, 4'hc, 4'h7, 4'h1, 4'h5, 4'hf, 4'hd, 4'h8,
        4'h4, 4'ha, 4'h9, 4'he, 4'h0, 4'h3, 4'hb, 4'h2},
      '{4'h4, 4'hb, 4'ha, 4'h0, 4'h7, 4'h2, 4'h1, 4'hd,
        4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hc, 4'hf, 4'he},
      '{4'hd, 4'hb, 4'h4, 4'h1, 4'h3, 4'hf, 4'h5, 4'h9,
        4'h0, 4'ha, 4'he, 4'h7, 4'h6, 4'h8, 4'h2, 4'hc},
      '{4'h1, 4'hf, 4'hd, 4'h0, 4'h5, 4'h7, 4'ha, 4'h4,
        4'h9, 4'h2, 4'h3, 4'he, 4'h6, 4'hb, 4'h8, 4'hc}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic [63:0]          req_data_block;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [63:0]          rsp_result_block;
   logic                 csr_write;
   logic [KEY_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;

   // Key copy used by the predictor, and the ciphered blocks still owed.
   logic [WORD_W-1:0] key_copy [KEY_WORDS];
   logic [63:0]       owed_blocks [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  encrypt_count  = 0;
   int  decrypt_count  = 0;
   int  key_count      = 1;
   int  hold_request   = 0;
   bit  send_idle_on   = 1'b0;
   bit  recv_idle_on   = 1'b0;

   gost_block_cipher dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_block   (req_data_block),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_block (rsp_result_block),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Full 32-round Feistel computation under the current key copy.
   function automatic logic [63:0] cipher_block(input logic mode, input logic [63:0] blk);
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] sub;
      logic [WORD_W-1:0] mixed;
      int                word_sel;
      left  = blk[63:32];
      right = blk[31:0];
      for (int r = 0; r < PIPE_DEPTH; r++) begin
         // Encryption runs forward for three passes, decryption for one.
         if ((mode == MODE_ENCRYPT) ? (r < 24) : (r < 8)) begin
            word_sel = r % 8;
         end else begin
            word_sel = 7 - (r % 8);
         end
         sum = right + key_copy[word_sel];
         for (int n = 0; n < 8; n++) begin
            sub[4*n +: 4] = SUBST[n][sum[4*n +: 4]];
         end
         mixed = left ^ {sub[20:0], sub[31:21]};
         left  = right;
         right = mixed;
      end
      return {right, left};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // Result check first, then record the block accepted at the same edge.
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (owed_blocks.size() == 0) begin
               report_mismatch("result_block with no block outstanding",
                               rsp_result_block, 64'h0);
            end else begin
               want = owed_blocks.pop_front();
               if (rsp_result_block !== want) begin
                  report_mismatch("result_block", rsp_result_block, want);
               end
            end
         end
         if (req_valid && req_ready) begin
            owed_blocks.push_back(cipher_block(req_mode, req_data_block));
            if (req_mode == MODE_ENCRYPT) begin
               encrypt_count++;
            end else begin
               decrypt_count++;
            end
         end
      end
   end

   // Receiver: random stalls, plus long hold-offs counted here on request.
   always @(posedge clock) begin
      int hold_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_idle_on) begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d blocks outstanding",
                  cycle_count, owed_blocks.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Offers one block and returns at the edge where the transaction is accepted.
   task automatic send_block(input logic mode, input logic [63:0] blk);
      while (send_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_data_block <= blk;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic send_random_blocks(input int count);
      for (int i = 0; i < count; i++) begin
         send_block(1'($urandom_range(1)), {$urandom, $urandom});
      end
   endtask

   // Waits for every owed result, then lets the pipeline settle.
   task automatic wait_idle();
      stop_sending();
      while (owed_blocks.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // Writes all eight key words on consecutive edges; only called while idle.
   task automatic load_key(input logic [WORD_W-1:0] words [KEY_WORDS]);
      for (int i = 0; i < KEY_WORDS; i++) begin
         csr_write   <= 1'b1;
         csr_index   <= KEY_IDX_W'(i);
         csr_data    <= words[i];
         key_copy[i] = words[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      key_count++;
   endtask

   task automatic load_random_key();
      logic [WORD_W-1:0] words [KEY_WORDS];
      foreach (words[i]) words[i] = $urandom;
      load_key(words);
   endtask

   // Reset key: all zero words, with the extreme blocks in both modes.
   task automatic test_reset_key();
      send_block(MODE_ENCRYPT, 64'h0);
      send_block(MODE_DECRYPT, 64'h0);
      send_block(MODE_ENCRYPT, '1);
      send_block(MODE_DECRYPT, '1);
      wait_idle();
   endtask

   // All-ones key against edge patterns in each half, both directions.
   task automatic test_extreme_blocks();
      logic [WORD_W-1:0] words [KEY_WORDS];
      logic [63:0]       patterns [6];
      foreach (words[i]) words[i] = '1;
      patterns = '{64'h0, '1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                   64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff};
      load_key(words);
      foreach (patterns[i]) begin
         send_block(MODE_ENCRYPT, patterns[i]);
         send_block(MODE_DECRYPT, patterns[i]);
      end
      wait_idle();
   endtask

   // Distinct key words so that a wrong word order shows up.
   task automatic test_key_order();
      logic [WORD_W-1:0] words [KEY_WORDS];
      foreach (words[i]) words[i] = (i % 2 == 0) ? 32'h8000_0000 + i : 32'h0000_0001 << (i * 4);
      load_key(words);
      send_block(MODE_ENCRYPT, 64'h0123_4567_89ab_cdef);
      send_block(MODE_DECRYPT, 64'h0123_4567_89ab_cdef);
      send_block(MODE_ENCRYPT, 64'hfedc_ba98_7654_3210);
      send_block(MODE_DECRYPT, 64'hfedc_ba98_7654_3210);
      wait_idle();
   endtask

   // Random blocks and modes with both sides idling at random, across key changes.
   task automatic test_random_traffic();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      for (int phase = 0; phase < 3; phase++) begin
         load_random_key();
         send_random_blocks(90);
         wait_idle();
      end
   endtask

   // A long stretch at full rate on both sides.
   task automatic test_full_rate();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      load_random_key();
      send_random_blocks(60);
      wait_idle();
   endtask

   // Receiver holds off while blocks keep coming, so the pipeline fills and stalls input.
   task automatic test_backpressure();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b1;
      hold_request = 150;
      send_random_blocks(70);
      wait_idle();
      send_idle_on = 1'b1;
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_ENCRYPT;
      req_data_block <= 64'h0;
      csr_write      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      foreach (key_copy[i]) key_copy[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_key();
      test_extreme_blocks();
      test_key_order();
      test_random_traffic();
      test_full_rate();
      test_backpressure();

      $display("Covered %0d encrypted and %0d decrypted blocks under %0d keys,",
               encrypt_count, decrypt_count, key_count);
      $display("including full-rate streaming and a long output stall.");
      if (mismatch_count == 0 && owed_blocks.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/gst_pkg.sv
rtl/gst_key_regs.sv
rtl/gst_round.sv
rtl/gost_block_cipher.sv
rtl/gst_checker.sv
dv/tb_top.sv
